// ===== sv/mecr_pkg.sv =====
package mecr_pkg;

  localparam int CFG_BITS = 13;
  localparam int CFG_INDEX_BITS = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = CFG_BITS'(480);

  typedef struct packed {
    logic line_end;
    logic frame_start;
  } pos_flags_t;

endpackage

// ===== sv/mecr_position.sv =====
module mecr_position #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mecr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mecr_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                  step,
  output mecr_pkg::pos_flags_t                  flags
);

  localparam int CNT_BITS = $clog2(MAX_DIM);
  localparam int DIM_BITS = (mecr_pkg::CFG_BITS > CNT_BITS + 1) ?
                            mecr_pkg::CFG_BITS : CNT_BITS + 1;

  logic [mecr_pkg::CFG_BITS-1:0] frame_width;
  logic [mecr_pkg::CFG_BITS-1:0] frame_height;
  logic [CNT_BITS-1:0]           column_count;
  logic [CNT_BITS-1:0]           line_count;

  logic [DIM_BITS-1:0] width_eff;
  logic [DIM_BITS-1:0] height_eff;
  logic                last_line;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [mecr_pkg::CFG_BITS-1:0] v);
    logic [DIM_BITS-1:0] wide;
    wide = DIM_BITS'(v);
    if (wide == '0) begin
      return DIM_BITS'(1);
    end else if (wide > DIM_BITS'(MAX_DIM)) begin
      return DIM_BITS'(MAX_DIM);
    end
    return wide;
  endfunction

  always_comb begin
    width_eff = clamp_dim(frame_width);
    height_eff = clamp_dim(frame_height);
    flags.frame_start = (column_count == '0) && (line_count == '0);
    flags.line_end = DIM_BITS'(column_count) >= (width_eff - DIM_BITS'(1));
    last_line = DIM_BITS'(line_count) >= (height_eff - DIM_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= mecr_pkg::FRAME_WIDTH_RESET;
      frame_height <= mecr_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mecr_pkg::REG_FRAME_WIDTH:  frame_width <= cfg_data;
        mecr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_count <= '0;
    end else if (step) begin
      if (flags.line_end) begin
        column_count <= '0;
        line_count <= last_line ? '0 : line_count + CNT_BITS'(1);
      end else begin
        column_count <= column_count + CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== sv/mecr_sqrt_cell.sv =====
module mecr_sqrt_cell #(
  parameter int ROOT_BITS = 18,
  parameter int SIDE_BITS = 19
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2*ROOT_BITS-1:0]   in_rad,
  input  logic [ROOT_BITS-1:0]     in_root,
  input  logic [ROOT_BITS+1:0]     in_rem,
  input  logic [SIDE_BITS-1:0]     in_side,
  output logic                     out_valid,
  output logic [2*ROOT_BITS-1:0]   out_rad,
  output logic [ROOT_BITS-1:0]     out_root,
  output logic [ROOT_BITS+1:0]     out_rem,
  output logic [SIDE_BITS-1:0]     out_side
);

  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int REM_BITS = ROOT_BITS + 2;

  logic [REM_BITS-1:0]  rem_sh;
  logic [REM_BITS-1:0]  trial;
  logic                 fits;
  logic [REM_BITS-1:0]  rem_next;
  logic [ROOT_BITS-1:0] root_next;

  always_comb begin
    rem_sh = {in_rem[REM_BITS-3:0], in_rad[RAD_BITS-1 -: 2]};
    trial = {in_root, 2'b01};
    fits = rem_sh >= trial;
    rem_next = fits ? rem_sh - trial : rem_sh;
    root_next = {in_root[ROOT_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad <= {in_rad[RAD_BITS-3:0], 2'b00};
      out_root <= root_next;
      out_rem <= rem_next;
      out_side <= in_side;
    end
  end

endmodule

// ===== sv/min_eigenvalue_corner_response_core.sv =====
// Pipeline: stage 0, stage 1, stage 2, the square-root cells, then the output register.
// Throughput: one pixel per cycle; the square root is a row of TERM_BITS + 2 cells,
// one root bit per cell, and the whole pipeline holds while the output stalls.
// Reset: synchronous, clears valid flags and counters, frame size back to 640 x 480.
module min_eigenvalue_corner_response_core #(
  parameter int TERM_BITS = 16,
  parameter int MAX_DIM = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a_term, b_term, c_term from bit 0 up
  input  logic [((3*TERM_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // response
  output logic [((TERM_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // line_end
  output logic                                  m_axis_tlast,
  // frame_start
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mecr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mecr_pkg::CFG_BITS-1:0]         cfg_data
);

  localparam int ROOT_BITS = TERM_BITS + 2;
  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int SUM_BITS = TERM_BITS + 1;
  localparam int SIDE_BITS = SUM_BITS + 2;
  localparam int OUT_W = ((TERM_BITS + 7) / 8) * 8;

  logic en;
  logic accept;

  logic [TERM_BITS-1:0] a_term;
  logic [TERM_BITS-1:0] b_term;
  logic [TERM_BITS-1:0] c_term;

  mecr_pkg::pos_flags_t flags;

  // stage 0
  logic                 v0;
  logic [TERM_BITS-1:0] diff0;
  logic [TERM_BITS-1:0] c0;
  logic [SIDE_BITS-1:0] side0;
  // stage 1
  logic                   v1;
  logic [2*TERM_BITS-1:0] dd1;
  logic [2*TERM_BITS-1:0] cc1;
  logic [SIDE_BITS-1:0]   side1;
  // stage 2
  logic                 v2;
  logic [RAD_BITS-1:0]  rad2;
  logic [SIDE_BITS-1:0] side2;

  logic                 ch_valid [0:ROOT_BITS];
  logic [RAD_BITS-1:0]  ch_rad   [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] ch_root  [0:ROOT_BITS];
  logic [REM_BITS-1:0]  ch_rem   [0:ROOT_BITS];
  logic [SIDE_BITS-1:0] ch_side  [0:ROOT_BITS];

  logic [ROOT_BITS:0]   root_ceil;
  logic [ROOT_BITS:0]   sum_wide;
  logic [ROOT_BITS:0]   margin;
  logic [TERM_BITS-1:0] resp_next;

  logic                 out_valid;
  logic [TERM_BITS-1:0] response;
  logic                 frame_start;
  logic                 line_end;

  assign en = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept = s_axis_tvalid && en;
  assign cfg_ready = 1'b1;

  assign a_term = s_axis_tdata[TERM_BITS-1:0];
  assign b_term = s_axis_tdata[2*TERM_BITS-1:TERM_BITS];
  assign c_term = s_axis_tdata[3*TERM_BITS-1:2*TERM_BITS];

  mecr_position #(
    .MAX_DIM(MAX_DIM)
  ) u_position (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .step(accept),
    .flags(flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff0 <= (a_term >= b_term) ? a_term - b_term : b_term - a_term;
      c0 <= c_term;
      side0 <= {flags.line_end, flags.frame_start,
                SUM_BITS'(a_term) + SUM_BITS'(b_term)};
      dd1 <= (2*TERM_BITS)'(diff0) * (2*TERM_BITS)'(diff0);
      cc1 <= (2*TERM_BITS)'(c0) * (2*TERM_BITS)'(c0);
      side1 <= side0;
      rad2 <= RAD_BITS'(dd1) + (RAD_BITS'(cc1) << 2);
      side2 <= side1;
    end
  end

  assign ch_valid[0] = v2;
  assign ch_rad[0] = rad2;
  assign ch_root[0] = '0;
  assign ch_rem[0] = '0;
  assign ch_side[0] = side2;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    mecr_sqrt_cell #(
      .ROOT_BITS(ROOT_BITS),
      .SIDE_BITS(SIDE_BITS)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .in_valid(ch_valid[i]),
      .in_rad(ch_rad[i]),
      .in_root(ch_root[i]),
      .in_rem(ch_rem[i]),
      .in_side(ch_side[i]),
      .out_valid(ch_valid[i+1]),
      .out_rad(ch_rad[i+1]),
      .out_root(ch_root[i+1]),
      .out_rem(ch_rem[i+1]),
      .out_side(ch_side[i+1])
    );
  end

  always_comb begin
    root_ceil = (ROOT_BITS+1)'(ch_root[ROOT_BITS])
              + (ROOT_BITS+1)'(ch_rem[ROOT_BITS] != '0);
    sum_wide = (ROOT_BITS+1)'(ch_side[ROOT_BITS][SUM_BITS-1:0]);
    margin = sum_wide - root_ceil;
    resp_next = (sum_wide > root_ceil) ? margin[TERM_BITS:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ch_valid[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      response <= resp_next;
      frame_start <= ch_side[ROOT_BITS][SUM_BITS];
      line_end <= ch_side[ROOT_BITS][SUM_BITS+1];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = OUT_W'(response);
  assign m_axis_tlast = line_end;
  assign m_axis_tuser = frame_start;

endmodule
